// ----- design/plst_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the positional list store.
// Used by plst_cell and positional_list_store_top; depends on nothing.
package plst_pkg;

    localparam int WORD_W = 32;

    localparam logic [2:0] KIND_APPEND_TAIL = 3'd0;
    localparam logic [2:0] KIND_REMOVE_TAIL = 3'd1;
    localparam logic [2:0] KIND_INSERT_HEAD = 3'd2;
    localparam logic [2:0] KIND_REMOVE_HEAD = 3'd3;
    localparam logic [2:0] KIND_INSERT_AT   = 3'd4;
    localparam logic [2:0] KIND_ERASE_AT    = 3'd5;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_BADPOS = 2'd2;
    localparam logic [1:0] STATUS_FULL   = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] word;
    } cell_cmd_t;

endpackage

// ----- design/plst_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one word and shifts with its neighbors.
// Depends on plst_pkg.
module plst_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                       aclk,
    input  plst_pkg::cell_cmd_t        cmd,
    input  logic [IDX_W-1:0]           at,
    input  logic [plst_pkg::WORD_W-1:0] left_data,
    input  logic [plst_pkg::WORD_W-1:0] right_data,
    output logic [plst_pkg::WORD_W-1:0] data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [plst_pkg::WORD_W-1:0] data_reg;
    logic [plst_pkg::WORD_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            plst_pkg::CELL_INSERT: begin
                if (MY_IDX > at) begin
                    data_next = left_data;
                end else if (MY_IDX == at) begin
                    data_next = cmd.word;
                end
            end
            plst_pkg::CELL_ERASE: begin
                if (MY_IDX >= at) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- design/positional_list_store_top.sv -----
`timescale 1ns / 1ps
// Top level of the positional list store: request control and the chain of cells.
// Depends on plst_pkg and plst_cell.

// An ordered list of up to CAPACITY signed 32-bit words kept in a row of cells that
// shift up on insert and down on erase, all together. Each request is captured, then
// the sequencer applies it to the whole chain at once, then, once the output is free,
// the head, the tail (read from the cell at count minus one) and the count are
// formed into the result register. A new request is accepted while a finished
// result still waits on the output. The stored words need no clearing after reset;
// of the list itself only the count is reset.
module positional_list_store_top #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind [2:0], position [7:3], value [39:8]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status [1:0], head_value [33:2], tail_value [65:34], entry_count [70:66],
    // is_empty [71], is_full [72], zero fill [79:73]
    output logic [79:0] m_axis_tdata
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W  = ((CNT_W > 5) ? CNT_W : 5) + 1;
    localparam int WORD_W = plst_pkg::WORD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_REPORT
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [1:0]           status_reg, status_next;
    logic [2:0]           kind_reg;
    logic [4:0]           pos_reg;
    logic [WORD_W-1:0]    word_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [WORD_W-1:0]    out_head_reg, out_head_next;
    logic [WORD_W-1:0]    out_tail_reg, out_tail_next;
    logic [4:0]           out_count_reg, out_count_next;
    logic                 out_empty_reg, out_empty_next;
    logic                 out_full_reg, out_full_next;

    plst_pkg::cell_cmd_t  cell_cmd;
    logic [IDX_W-1:0]     at_sel;
    logic [WORD_W-1:0]    cell_data [CAPACITY];

    logic                 accept;
    logic                 is_full_now;
    logic                 is_empty_now;
    logic [CMP_W-1:0]     pos_cmp;
    logic [CMP_W-1:0]     cnt_cmp;
    logic [4:0]           pos_m1;
    logic [IDX_W-1:0]     tail_idx;
    logic [CMP_W-1:0]     cnt_wide;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign is_full_now  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty_now = (count_reg == '0);
    assign pos_cmp      = CMP_W'(pos_reg);
    assign cnt_cmp      = CMP_W'(count_reg);
    assign cnt_wide     = CMP_W'(count_reg);
    assign pos_m1       = pos_reg - 5'd1;
    assign tail_idx     = IDX_W'(count_reg - CNT_W'(1));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        cell_cmd.op     = plst_pkg::CELL_HOLD;
        cell_cmd.word   = word_reg;
        at_sel          = '0;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_head_next   = out_head_reg;
        out_tail_next   = out_tail_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        out_full_next   = out_full_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                status_next = plst_pkg::STATUS_OK;
                state_next  = ST_REPORT;
                case (kind_reg)
                    plst_pkg::KIND_APPEND_TAIL: begin
                        if (is_full_now) begin
                            status_next = plst_pkg::STATUS_FULL;
                        end else begin
                            cell_cmd.op = plst_pkg::CELL_INSERT;
                            at_sel      = IDX_W'(count_reg);
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    plst_pkg::KIND_REMOVE_TAIL: begin
                        if (is_empty_now) begin
                            status_next = plst_pkg::STATUS_EMPTY;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    plst_pkg::KIND_INSERT_HEAD: begin
                        if (is_full_now) begin
                            status_next = plst_pkg::STATUS_FULL;
                        end else begin
                            cell_cmd.op = plst_pkg::CELL_INSERT;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    plst_pkg::KIND_REMOVE_HEAD: begin
                        if (is_empty_now) begin
                            status_next = plst_pkg::STATUS_EMPTY;
                        end else begin
                            cell_cmd.op = plst_pkg::CELL_ERASE;
                            count_next  = count_reg - CNT_W'(1);
                        end
                    end
                    plst_pkg::KIND_INSERT_AT: begin
                        if (pos_reg == 5'd0 || pos_cmp > cnt_cmp + CMP_W'(1)) begin
                            status_next = plst_pkg::STATUS_BADPOS;
                        end else if (is_full_now) begin
                            status_next = plst_pkg::STATUS_FULL;
                        end else begin
                            cell_cmd.op = plst_pkg::CELL_INSERT;
                            at_sel      = IDX_W'(pos_m1);
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    plst_pkg::KIND_ERASE_AT: begin
                        if (is_empty_now) begin
                            status_next = plst_pkg::STATUS_EMPTY;
                        end else if (pos_reg == 5'd0 || pos_cmp > cnt_cmp) begin
                            status_next = plst_pkg::STATUS_BADPOS;
                        end else begin
                            cell_cmd.op = plst_pkg::CELL_ERASE;
                            at_sel      = IDX_W'(pos_m1);
                            count_next  = count_reg - CNT_W'(1);
                        end
                    end
                    default: begin
                        status_next = plst_pkg::STATUS_OK;
                    end
                endcase
            end
            ST_REPORT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next    = 1'b1;
                    out_status_next = status_reg;
                    out_head_next   = is_empty_now ? '0 : cell_data[0];
                    out_tail_next   = is_empty_now ? '0 : cell_data[tail_idx];
                    out_count_next  = cnt_wide[4:0];
                    out_empty_next  = is_empty_now;
                    out_full_next   = is_full_now;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_head_reg   <= out_head_next;
        out_tail_reg   <= out_tail_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
        out_full_reg   <= out_full_next;
        if (accept) begin
            kind_reg <= s_axis_tdata[2:0];
            pos_reg  <= s_axis_tdata[7:3];
            word_reg <= s_axis_tdata[39:8];
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_W-1:0] left_in;
        logic [WORD_W-1:0] right_in;

        if (i == 0) begin : g_first
            assign left_in = cell_data[i];
        end else begin : g_left
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_in = cell_data[i];
        end else begin : g_right
            assign right_in = cell_data[i+1];
        end

        plst_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd),
            .at         (at_sel),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, out_full_reg, out_empty_reg, out_count_reg,
                            out_tail_reg, out_head_reg, out_status_reg};

endmodule
